// ===== src/rps_pkg.sv =====
package rps_pkg;

    // Field and datapath widths.
    localparam int NOTE_W  = 5;
    localparam int BPM_W   = 9;
    localparam int STEP_W  = 4;
    localparam int TIME_W  = 32;
    localparam int KIND_W  = 2;
    localparam int SEL_W   = 2;
    localparam int COL_W   = 3;
    localparam int ROM_COLS = 8;

    // The interval divider works on (480000 + d) / (2 * d), d = note * bpm.
    localparam int D_W    = NOTE_W + BPM_W;
    localparam int DEN_W  = D_W + 1;
    localparam int NUM_W  = 19;
    localparam logic [NUM_W-1:0] NUM_BASE = 19'd480000;

    // Strike codes, which are also the step kinds held in the pattern table.
    localparam logic [KIND_W-1:0] STRIKE_NONE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DUM    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TEK    = 2'd2;

    // Register index, taken from paddr bit 2.
    localparam logic REG_RHYTHM_SELECT = 1'b0;
    localparam logic REG_TEMPO_BPM     = 1'b1;

    localparam logic [BPM_W-1:0] TEMPO_RESET = 9'd120;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [NOTE_W-1:0] note;
    } rps_entry_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } rps_div_req_t;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quo;
    } rps_div_rsp_t;

    localparam logic [STEP_W-1:0] PAT_LEN [4] = '{4'd5, 4'd5, 4'd5, 4'd8};

    // Patterns: bayo, chiftetelli, zonaradikos, tsamikos.
    localparam rps_entry_t PAT_ROM [4][ROM_COLS] = '{
        '{'{KIND_DUM, 5'd4}, '{KIND_TEK, 5'd8}, '{KIND_TEK, 5'd8}, '{KIND_DUM, 5'd4},
          '{KIND_TEK, 5'd4}, '{STRIKE_NONE, 5'd0}, '{STRIKE_NONE, 5'd0},
          '{STRIKE_NONE, 5'd0}},
        '{'{KIND_DUM, 5'd8}, '{KIND_TEK, 5'd4}, '{KIND_TEK, 5'd8}, '{KIND_DUM, 5'd4},
          '{KIND_TEK, 5'd4}, '{STRIKE_NONE, 5'd0}, '{STRIKE_NONE, 5'd0},
          '{STRIKE_NONE, 5'd0}},
        '{'{KIND_DUM, 5'd4}, '{KIND_TEK, 5'd8}, '{KIND_TEK, 5'd8}, '{KIND_TEK, 5'd8},
          '{KIND_TEK, 5'd8}, '{STRIKE_NONE, 5'd0}, '{STRIKE_NONE, 5'd0},
          '{STRIKE_NONE, 5'd0}},
        '{'{KIND_DUM, 5'd12}, '{KIND_TEK, 5'd16}, '{KIND_TEK, 5'd8}, '{KIND_TEK, 5'd8},
          '{KIND_DUM, 5'd16}, '{KIND_TEK, 5'd16}, '{KIND_TEK, 5'd16},
          '{KIND_TEK, 5'd16}}
    };

endpackage

// ===== src/rps_div.sv =====
module rps_div
    import rps_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  rps_div_req_t req,
    output rps_div_rsp_t rsp
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] num_reg, num_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           fits;

    // One restoring step per cycle: bring down the next numerator bit and
    // subtract the divisor when it fits.
    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        num_next  = num_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            num_next  = req.num;
            den_next  = req.den;
            rem_next  = '0;
            quo_next  = '0;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[NUM_W-2:0], 1'b0};
            quo_next = {quo_reg[NUM_W-2:0], fits};
            rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

// ===== src/rhythm_pattern_sequencer.sv =====
// Channel   Signals                          Direction  Meaning
// input     in_valid, in_stall, now_ms       in         one time sample per transfer
// output    out_valid, out_stall, strike,    out        one strike result per transfer
//           beat_position
// config    psel, penable, pwrite, paddr,    in/out     rhythm_select at 0, tempo_bpm at 4
//           pwdata, prdata, pready
//
// When a previous beat is recorded, the input transfer starts the bit-serial divider, which
// resolves one quotient bit of the 19-bit beat interval per cycle; its registered result
// then decides the item, which goes to the output register. With no previous beat the
// result is valid in the cycle right after the transfer. The block takes one item at a
// time: in_stall is high from the input transfer until the result has left through the
// output register, so a new item is taken only once the last one has left. Reset is
// asynchronous and active low; it returns the first step, tempo 120, pattern 0 and an
// empty beat history. A stalled result simply holds.
module rhythm_pattern_sequencer
    import rps_pkg::*;
#(
    parameter int MAX_STEPS = 8
)
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,

    input  logic                in_valid,
    output logic                in_stall,
    input  logic [TIME_W-1:0]   now_ms,

    output logic                out_valid,
    input  logic                out_stall,
    output logic [KIND_W-1:0]   strike,
    output logic [STEP_W-1:0]   beat_position
);

    // The usable pattern length is capped both by the parameter and by the table.
    localparam int LEN_CAP = (MAX_STEPS < ROM_COLS) ? MAX_STEPS : ROM_COLS;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_OUT  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [SEL_W-1:0]  rhythm_select_reg, rhythm_select_next;
    logic [BPM_W-1:0]  tempo_bpm_reg, tempo_bpm_next;

    // Sequencer state that persists between items.
    logic [STEP_W-1:0] step_reg, step_next;
    logic [TIME_W-1:0] last_time_reg, last_time_next;
    logic [NOTE_W-1:0] last_note_reg, last_note_next;

    // Per-item working registers.
    logic [STEP_W-1:0] pos_reg, pos_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [TIME_W-1:0] elapsed_reg, elapsed_next;
    rps_entry_t        entry_reg, entry_next;
    logic [STEP_W-1:0] len_reg, len_next;

    // Output register.
    logic              out_valid_reg, out_valid_next;
    logic [KIND_W-1:0] strike_reg, strike_next;
    logic [STEP_W-1:0] beat_pos_reg, beat_pos_next;

    logic              cfg_write;
    logic              in_xfer;
    logic [STEP_W-1:0] pat_len;
    logic [STEP_W-1:0] cur_len;
    logic [STEP_W-1:0] cur_pos;
    logic [STEP_W-1:0] col_full;
    logic [BPM_W-1:0]  bpm_eff;
    logic [D_W-1:0]    d_prod;
    logic              resolve;
    logic              fire;

    rps_div_req_t      div_req;
    rps_div_rsp_t      div_rsp;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_TEMPO_BPM) ? {{(32 - BPM_W){1'b0}}, tempo_bpm_reg}
                                                   : {{(32 - SEL_W){1'b0}}, rhythm_select_reg};

    assign in_stall = (state_reg != S_IDLE);
    assign in_xfer  = in_valid && !in_stall;

    // Length of the selected pattern, and the step to evaluate. A step that is zero
    // or lies past the end (for instance after a pattern change) restarts at one.
    assign pat_len  = PAT_LEN[rhythm_select_reg];
    assign cur_len  = (pat_len > STEP_W'(LEN_CAP)) ? STEP_W'(LEN_CAP) : pat_len;
    assign cur_pos  = ((step_reg == '0) || (step_reg > cur_len)) ? STEP_W'(1) : step_reg;
    assign col_full = cur_pos - 1'b1;

    // Beat interval of the previous note: (480000 + d) / (2 * d), rounding half up.
    // A zero tempo counts as the slowest tempo.
    assign bpm_eff = (tempo_bpm_reg == '0) ? BPM_W'(1) : tempo_bpm_reg;
    assign d_prod  = D_W'(last_note_reg) * D_W'(bpm_eff);

    assign div_req.start = in_xfer && (last_note_reg != '0);
    assign div_req.num   = NUM_BASE + NUM_W'(d_prod);
    assign div_req.den   = {d_prod, 1'b0};

    rps_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // The item is decided either right at the transfer, when no beat has been
    // recorded yet, or when the divider hands back the interval.
    always_comb
    begin
        resolve = 1'b0;
        fire    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                resolve = in_xfer && (last_note_reg == '0);
                fire    = resolve;
            end
            S_DIV:
            begin
                resolve = div_rsp.done;
                fire    = div_rsp.done && (elapsed_reg >= TIME_W'(div_rsp.quo));
            end
            S_OUT:
            begin
                resolve = 1'b0;
                fire    = 1'b0;
            end
            default:
            begin
                resolve = 1'b0;
                fire    = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next         = state_reg;
        rhythm_select_next = rhythm_select_reg;
        tempo_bpm_next     = tempo_bpm_reg;
        step_next          = step_reg;
        last_time_next     = last_time_reg;
        last_note_next     = last_note_reg;
        pos_next           = pos_reg;
        now_next           = now_reg;
        elapsed_next       = elapsed_reg;
        entry_next         = entry_reg;
        len_next           = len_reg;
        out_valid_next     = out_valid_reg;
        strike_next        = strike_reg;
        beat_pos_next      = beat_pos_reg;

        if (cfg_write)
        begin
            unique case (paddr[2])
                REG_RHYTHM_SELECT: rhythm_select_next = pwdata[SEL_W-1:0];
                REG_TEMPO_BPM:     tempo_bpm_next     = pwdata[BPM_W-1:0];
                default:           rhythm_select_next = rhythm_select_reg;
            endcase
        end

        // Capture everything the item needs at the transfer.
        if (in_xfer)
        begin
            pos_next     = cur_pos;
            now_next     = now_ms;
            elapsed_next = now_ms - last_time_reg;
            entry_next   = PAT_ROM[rhythm_select_reg][col_full[COL_W-1:0]];
            len_next     = cur_len;
            step_next    = cur_pos;
        end

        if (resolve)
        begin
            // Values for the immediate path come straight from the transfer.
            logic [STEP_W-1:0] rpos;
            logic [STEP_W-1:0] rlen;
            rps_entry_t        rent;
            logic [TIME_W-1:0] rnow;
            rpos = (state_reg == S_IDLE) ? cur_pos : pos_reg;
            rlen = (state_reg == S_IDLE) ? cur_len : len_reg;
            rent = (state_reg == S_IDLE) ? PAT_ROM[rhythm_select_reg][col_full[COL_W-1:0]]
                                         : entry_reg;
            rnow = (state_reg == S_IDLE) ? now_ms : now_reg;

            out_valid_next = 1'b1;
            beat_pos_next  = rpos;
            strike_next    = fire ? rent.kind : STRIKE_NONE;
            if (fire)
            begin
                last_time_next = rnow;
                last_note_next = rent.note;
                step_next      = (rpos >= rlen) ? STEP_W'(1) : rpos + 1'b1;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = (last_note_reg == '0) ? S_OUT : S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            rhythm_select_reg <= '0;
            tempo_bpm_reg     <= TEMPO_RESET;
            step_reg          <= STEP_W'(1);
            last_time_reg     <= '0;
            last_note_reg     <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            rhythm_select_reg <= rhythm_select_next;
            tempo_bpm_reg     <= tempo_bpm_next;
            step_reg          <= step_next;
            last_time_reg     <= last_time_next;
            last_note_reg     <= last_note_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        now_reg      <= now_next;
        elapsed_reg  <= elapsed_next;
        entry_reg    <= entry_next;
        len_reg      <= len_next;
        strike_reg   <= strike_next;
        beat_pos_reg <= beat_pos_next;
    end

    assign out_valid     = out_valid_reg;
    assign strike        = strike_reg;
    assign beat_position = beat_pos_reg;

endmodule
